// File: src/pce_pkg.sv
package pce_pkg;

    localparam logic [1:0] CMD_SAMPLE    = 2'd0;
    localparam logic [1:0] CMD_CLR_STATS = 2'd1;
    localparam logic [1:0] CMD_CLR_ENV   = 2'd2;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;

    localparam logic [63:0] HASH_OFFSET = 64'd1469598103934665603;

    localparam int BLK_LOG2    = 9;
    localparam int BLK_SAMPLES = 1 << BLK_LOG2;
    localparam int ENERGY_W    = 40;
    localparam int SQRT_STEPS  = 16;
    localparam int QDEPTH      = 2;

    typedef enum logic [1:0] {
        K_SAMPLE,
        K_CLR_STATS,
        K_CLR_ENV
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] pcm;
        logic               clip;
    } t_entry;

    typedef enum logic [1:0] {
        B_IDLE,
        B_HASH,
        B_SQRT,
        B_EMIT
    } t_bstate;

    typedef struct packed {
        logic pop;
        logic hash_lo;
        logic hash_hi;
        logic sqrt_step;
        logic emit;
    } t_bctl;

    // One FNV-1a round: xor the byte, then multiply by 2^40 + 0x1B3 as shifts and adds.
    function automatic logic [63:0] hash_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// File: src/pce_in_if.sv
interface pce_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [23:0] sample_in;

    modport source (output valid, command, sample_in, input ready);
    modport sink   (input valid, command, sample_in, output ready);
endinterface

// File: src/pce_out_if.sv
interface pce_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pcm_out;
    logic               clipped;
    logic               block_done;
    logic [7:0]         block_level;
    logic [11:0]        block_index;
    logic [7:0]         level_peak;
    logic [63:0]        checksum;
    logic [31:0]        sample_count;
    logic [31:0]        clip_count;
    logic [15:0]        abs_max;
    logic [63:0]        square_sum;

    modport source (output valid, pcm_out, clipped, block_done, block_level, block_index,
                    level_peak, checksum, sample_count, clip_count, abs_max, square_sum,
                    input ready);
    modport sink   (input valid, pcm_out, clipped, block_done, block_level, block_index,
                    level_peak, checksum, sample_count, clip_count, abs_max, square_sum,
                    output ready);
endinterface

// File: src/pcm_convert_checksum_envelope.sv
// PCM converter with running checksum, statistics and a block RMS envelope.
// Input channel i_in carries a command and a signed Q2.22 sample. Command 0
// converts the sample to a rounded, saturated 16-bit value and yields one
// transaction on o_out. Commands 1 (clear statistics) and 2 (start utterance)
// change state only and yield nothing; code 3 is taken and dropped.
// The front converts and classifies in the cycle of acceptance and writes a
// two-entry queue. The back takes one item at a time: an ordinary sample
// passes the two hash rounds and the output load, and a sample that closes
// a 512-sample block also runs the 16 bit-pair square-root iterations
// before the output load. Commands change state on the pop and go no
// further; no new item is popped until the last one is in the output register.
// The result sits in an output register: when the receiver stalls, the back
// holds its finished item and the queue fills, then i_in.ready falls.
// Synchronous reset restores the hash offset, clears the statistics and block
// counters, the envelope state, the queue and the output valid.
module pcm_convert_checksum_envelope (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pce_in_if.sink     i_in,
    pce_out_if.source  o_out
);

    logic            w_push_valid;
    logic            w_push_ready;
    pce_pkg::t_entry w_push_data;
    logic            w_pop_valid;
    logic            w_pop_ready;
    pce_pkg::t_entry w_pop_data;

    pce_front u_front (
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    pce_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    pce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_clip_rails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.clipped) |->
            (o_out.pcm_out == 16'sh7fff || o_out.pcm_out == 16'sh8000))
        else $error("clipped result is not at a rail");

    a_idle_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.block_done) |->
            (o_out.block_level == 8'd0 && o_out.block_index == 12'd0))
        else $error("block fields set without a completed block");

    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.block_done) |-> (o_out.block_level <= o_out.level_peak))
        else $error("block level exceeds utterance peak");

    a_abs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.abs_max <= 16'd32768))
        else $error("absolute peak out of range");
`endif

endmodule

// File: src/pce_front.sv
module pce_front (
    pce_in_if.sink          i_in,
    output logic            o_push_valid,
    input  logic            i_push_ready,
    output pce_pkg::t_entry o_push_data
);

    logic signed [39:0] w_prod;
    logic signed [17:0] w_floor;
    logic [21:0]        w_rem;
    logic               w_up;
    logic signed [18:0] w_round;

    // Unused command codes are taken and dropped.
    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid && (i_in.command != pce_pkg::CMD_UNUSED);

    always_comb begin
        w_prod  = (40'(i_in.sample_in) <<< 15) - 40'(i_in.sample_in);
        w_floor = w_prod[39:22];
        w_rem   = w_prod[21:0];
        // Round half to even on the quotient by 2^22.
        w_up    = (w_rem > 22'h200000) || ((w_rem == 22'h200000) && w_floor[0]);
        w_round = 19'(w_floor) + 19'(w_up);

        o_push_data.pcm  = w_round[15:0];
        o_push_data.clip = 1'b0;
        if (w_round > 19'sd32767) begin
            o_push_data.pcm  = 16'sh7fff;
            o_push_data.clip = 1'b1;
        end else if (w_round < -19'sd32768) begin
            o_push_data.pcm  = 16'sh8000;
            o_push_data.clip = 1'b1;
        end

        case (i_in.command)
            pce_pkg::CMD_SAMPLE:    o_push_data.kind = pce_pkg::K_SAMPLE;
            pce_pkg::CMD_CLR_STATS: o_push_data.kind = pce_pkg::K_CLR_STATS;
            pce_pkg::CMD_CLR_ENV:   o_push_data.kind = pce_pkg::K_CLR_ENV;
            default:                o_push_data.kind = pce_pkg::K_SAMPLE;
        endcase
    end

endmodule

// File: src/pce_queue.sv
module pce_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  pce_pkg::t_entry i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output pce_pkg::t_entry o_pop_data
);

    localparam int PW = $clog2(pce_pkg::QDEPTH);

    pce_pkg::t_entry r_mem [pce_pkg::QDEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [PW:0]     r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_cnt != (PW+1)'(pce_pkg::QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

// File: src/pce_back.sv
module pce_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    output logic            o_pop_ready,
    input  pce_pkg::t_entry i_pop_data,
    pce_out_if.source       o_out
);

    pce_pkg::t_bstate r_state;
    pce_pkg::t_bstate n_state;
    pce_pkg::t_bctl   w_ctl;

    logic [63:0] r_hash;
    logic [31:0] r_count;
    logic [31:0] r_clips;
    logic [15:0] r_peak;
    logic [63:0] r_sqsum;
    logic [pce_pkg::ENERGY_W-1:0] r_energy;
    logic [pce_pkg::BLK_LOG2-1:0] r_pos;
    logic [11:0] r_blocks;
    logic [7:0]  r_envpeak;

    logic signed [15:0] r_pcm;
    logic               r_clip;
    logic               r_done;
    logic [31:0]        r_rad;
    logic [31:0]        r_root;
    logic [31:0]        r_bit;
    logic [3:0]         r_step;

    logic        r_ovalid;
    logic [7:0]  w_level;
    logic [7:0]  w_envpeak;
    logic [16:0] w_mag;
    logic [31:0] w_sq;
    logic [pce_pkg::ENERGY_W-1:0] w_energy;
    logic [31:0] w_trial;
    logic        w_out_free;

    assign w_out_free = !r_ovalid || o_out.ready;

    always_comb begin
        w_mag    = i_pop_data.pcm[15] ? 17'(-17'(i_pop_data.pcm)) : 17'(i_pop_data.pcm);
        w_sq     = 32'(w_mag) * 32'(w_mag);
        w_energy = r_energy + pce_pkg::ENERGY_W'(w_sq);
        w_trial  = r_root + r_bit;
        w_level  = 8'd0;
        if (r_done) begin
            w_level = (r_root[31:4] > 28'd255) ? 8'd255 : r_root[11:4];
        end
        w_envpeak = (w_level > r_envpeak) ? w_level : r_envpeak;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pce_pkg::B_IDLE: begin
                if (i_pop_valid && (i_pop_data.kind == pce_pkg::K_SAMPLE)) begin
                    n_state = pce_pkg::B_HASH;
                end
            end
            pce_pkg::B_HASH: n_state = r_done ? pce_pkg::B_SQRT : pce_pkg::B_EMIT;
            pce_pkg::B_SQRT: begin
                if (r_step == 4'(pce_pkg::SQRT_STEPS - 1)) begin
                    n_state = pce_pkg::B_EMIT;
                end
            end
            pce_pkg::B_EMIT: begin
                if (w_out_free) begin
                    n_state = pce_pkg::B_IDLE;
                end
            end
            default: n_state = pce_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        w_ctl = '0;
        case (r_state)
            pce_pkg::B_IDLE: begin
                w_ctl.pop     = i_pop_valid;
                w_ctl.hash_lo = i_pop_valid && (i_pop_data.kind == pce_pkg::K_SAMPLE);
            end
            pce_pkg::B_HASH: w_ctl.hash_hi = 1'b1;
            pce_pkg::B_SQRT: w_ctl.sqrt_step = 1'b1;
            pce_pkg::B_EMIT: w_ctl.emit = w_out_free;
            default: w_ctl = '0;
        endcase
    end

    assign o_pop_ready = w_ctl.pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pce_pkg::B_IDLE;
            r_hash    <= pce_pkg::HASH_OFFSET;
            r_count   <= '0;
            r_clips   <= '0;
            r_peak    <= '0;
            r_sqsum   <= '0;
            r_energy  <= '0;
            r_pos     <= '0;
            r_blocks  <= '0;
            r_envpeak <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.pop && (i_pop_data.kind == pce_pkg::K_CLR_STATS)) begin
                r_hash  <= pce_pkg::HASH_OFFSET;
                r_count <= '0;
                r_clips <= '0;
                r_peak  <= '0;
                r_sqsum <= '0;
            end
            if (w_ctl.pop && (i_pop_data.kind == pce_pkg::K_CLR_ENV)) begin
                r_energy  <= '0;
                r_pos     <= '0;
                r_blocks  <= '0;
                r_envpeak <= '0;
            end
            if (w_ctl.hash_lo) begin
                r_hash  <= pce_pkg::hash_step(r_hash, i_pop_data.pcm[7:0]);
                r_count <= r_count + 32'd1;
                r_clips <= r_clips + 32'(i_pop_data.clip);
                if (w_mag > 17'(r_peak)) begin
                    r_peak <= w_mag[15:0];
                end
                r_sqsum <= r_sqsum + 64'(w_sq);
                r_pos   <= r_pos + 1'b1;
                if (r_pos == pce_pkg::BLK_LOG2'(pce_pkg::BLK_SAMPLES - 1)) begin
                    r_energy <= '0;
                end else begin
                    r_energy <= w_energy;
                end
            end
            if (w_ctl.hash_hi) begin
                r_hash <= pce_pkg::hash_step(r_hash, r_pcm[15:8]);
            end
            if (w_ctl.emit) begin
                r_envpeak <= w_envpeak;
                if (r_done) begin
                    r_blocks <= r_blocks + 12'd1;
                end
            end
            if (w_ctl.emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath for the item in flight and the square-root iterations.
    always_ff @(posedge i_clk) begin
        if (w_ctl.hash_lo) begin
            r_pcm  <= i_pop_data.pcm;
            r_clip <= i_pop_data.clip;
            r_done <= (r_pos == pce_pkg::BLK_LOG2'(pce_pkg::BLK_SAMPLES - 1));
            r_rad  <= 32'(w_energy[pce_pkg::ENERGY_W-1:pce_pkg::BLK_LOG2]);
            r_root <= '0;
            r_bit  <= 32'h4000_0000;
            r_step <= '0;
        end
        if (w_ctl.sqrt_step) begin
            r_step <= r_step + 4'd1;
            r_bit  <= r_bit >> 2;
            if (r_rad >= w_trial) begin
                r_rad  <= r_rad - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
        end
        if (w_ctl.emit) begin
            o_out.pcm_out      <= r_pcm;
            o_out.clipped      <= r_clip;
            o_out.block_done   <= r_done;
            o_out.block_level  <= w_level;
            o_out.block_index  <= r_done ? r_blocks : 12'd0;
            o_out.level_peak   <= w_envpeak;
            o_out.checksum     <= r_hash;
            o_out.sample_count <= r_count;
            o_out.clip_count   <= r_clips;
            o_out.abs_max      <= r_peak;
            o_out.square_sum   <= r_sqsum;
        end
    end

    assign o_out.valid = r_ovalid;

endmodule
